// ===== sv/bbs_pkg.sv =====
package bbs_pkg;

   // fixed field widths
   localparam int LEN_W      = 7;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 12;
   localparam int MEAN_W     = 24;
   localparam int BAND_W     = 28;
   localparam int IN_W       = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd20;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION_GAIN = 2'd1;

   // control from the sequencer to the window store
   typedef struct packed {
      logic             push;
      logic             clear;
      logic [LEN_W-1:0] len;
   } win_ctl_type;

endpackage

// ===== sv/bbs_win.sv =====
module bbs_win #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bbs_pkg::win_ctl_type              ctl,
   input  logic [SAMPLE_BITS-1:0]            sample,
   output logic [SAMPLE_BITS-1:0]            old_sample,
   output logic [$clog2(WINDOW_MAX+1)-1:0]   fill
);

   localparam int NW = $clog2(WINDOW_MAX+1);
   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = ((NW > bbs_pkg::LEN_W) ? NW : bbs_pkg::LEN_W) + 1;

   logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic                   evict_ff, evict_in;
   logic [AW-1:0]          wp_ff, wp_in, w;
   logic [NW-1:0]          fill_ff, fill_in, f;
   logic [CW-1:0]          len_raw, len_ext, wm_ext, f_ext, w_ext, pos_sum, pos;

   // clamp length and find the slot that drops out of the window
   always_comb begin
      len_raw = {{(CW-bbs_pkg::LEN_W){1'b0}}, ctl.len};
      wm_ext  = CW'(WINDOW_MAX);
      len_ext = (len_raw > wm_ext) ? wm_ext : len_raw;
      f       = ctl.clear ? '0 : fill_ff;
      w       = ctl.clear ? '0 : wp_ff;
      f_ext   = CW'(f);
      w_ext   = CW'(w);
      evict_in = (f_ext >= len_ext);
      pos_sum = w_ext + wm_ext - len_ext;
      pos     = (pos_sum >= wm_ext) ? (pos_sum - wm_ext) : pos_sum;
      wp_in   = (w == AW'(WINDOW_MAX-1)) ? '0 : (w + AW'(1));
      fill_in = evict_in ? f : (f + NW'(1));
   end

   // position and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
         evict_ff <= 1'b0;
      end else if (ctl.push) begin
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         evict_ff <= evict_in;
      end else if (ctl.clear) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
      end
   end

   // sample store, old data read before the new sample lands
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         rd_ff  <= mem[pos[AW-1:0]];
         mem[w] <= sample;
      end
   end

   assign old_sample = evict_ff ? rd_ff : '0;
   assign fill       = fill_ff;

endmodule

// ===== sv/sliding_window_bollinger_band_top.sv =====
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: sample; tuser: series_start
// rsp      out  rsp_tvalid/rsp_tready  tdata: band_mean, band_upper, band_lower
// csr      in   csr_valid/csr_ready    csr_index, csr_data
// one request runs through the shared shift-add multiplier, the restoring dividers
// and the bit-pair square root one after another; no new request is taken until
// it is handed to the output register
// a suppressed request is taken while idle and gives no response
// reset clears counters and sums; the sample store needs no clearing
// a waiting response does not stop the next request from being taken
module sliding_window_bollinger_band_top #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bbs_pkg::IN_W-1:0]          req_tdata,  // [23:0] sample
   input  logic                              req_tuser,  // [0] series_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] band_mean, [51:24] band_upper, [79:52] band_lower
   output logic [79:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int NW   = $clog2(WINDOW_MAX+1);
   localparam int SB   = SAMPLE_BITS;
   localparam int SUMW = SB + NW;
   localparam int SQW  = 2*SB + NW;
   localparam int DW   = SQW + NW;
   localparam int SW   = DW + (DW % 2);
   localparam int HW   = SW / 2;
   localparam int RW   = HW + 2;
   localparam int MW   = SW + 28;
   localparam int MPW  = SUMW + 16;
   localparam int CNTW = $clog2(SW+1);
   localparam int BW   = bbs_pkg::BAND_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_SQ1  = 4'd2;
   localparam logic [3:0] ST_SQ2  = 4'd3;
   localparam logic [3:0] ST_MA   = 4'd4;
   localparam logic [3:0] ST_MB   = 4'd5;
   localparam logic [3:0] ST_MN   = 4'd6;
   localparam logic [3:0] ST_DV   = 4'd7;
   localparam logic [3:0] ST_DM   = 4'd8;
   localparam logic [3:0] ST_SR   = 4'd9;
   localparam logic [3:0] ST_MG   = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   logic [3:0]                   state_ff, state_in;
   logic [CNTW-1:0]              cnt_ff, cnt_in;
   logic [bbs_pkg::LEN_W-1:0]    wlen_ff, wlen_in;
   logic [bbs_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [SB-1:0]                s_ff, s_in;
   logic [SUMW-1:0]              sum_ff, sum_in;
   logic [SQW-1:0]               sq_ff, sq_in;
   logic [MW-1:0]                mc_ff, mc_in, acc_ff, acc_in, acc_new;
   logic [MPW-1:0]               mp_ff, mp_in;
   logic [SW-1:0]                d_ff, d_in;
   logic [2*NW-1:0]              nsq_ff, nsq_in, rem_ff, rem_in;
   logic [SUMW-1:0]              mq_ff, mq_in;
   logic [NW-1:0]                mrem_ff, mrem_in;
   logic [HW-1:0]                root_ff, root_in;
   logic [RW-1:0]                srem_ff, srem_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [79:0]                  rsp_data_ff, rsp_data_in;

   logic                         req_acc, suppress, csr_len_wr, mul_last;
   logic [2*NW:0]                dsh, dsub;
   logic [NW:0]                  msh, msub;
   logic [RW+1:0]                ssh, strial;
   logic [BW-1:0]                mean_ext, dev;
   logic [SB-1:0]                old_s;
   logic [NW-1:0]                n;
   bbs_pkg::win_ctl_type         wctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign suppress   = (wlen_ff == '0) || (gain_ff == '0);
   assign csr_len_wr = csr_valid && (csr_index == bbs_pkg::CSR_WINDOW_LENGTH);

   // window store control
   always_comb begin
      wctl.push  = req_acc && !suppress;
      wctl.clear = (req_acc && !suppress && req_tuser) || csr_len_wr;
      wctl.len   = wlen_ff;
   end

   bbs_win #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_win (
      .clock      (clock),
      .reset      (reset),
      .ctl        (wctl),
      .sample     (req_tdata[SB-1:0]),
      .old_sample (old_s),
      .fill       (n)
   );

   // step datapaths
   always_comb begin
      acc_new  = mp_ff[0] ? (acc_ff + mc_ff) : acc_ff;
      mul_last = (cnt_ff == CNTW'(1));
      dsh      = {rem_ff, d_ff[SW-1]};
      dsub     = dsh - {1'b0, nsq_ff};
      msh      = {mrem_ff, mq_ff[SUMW-1]};
      msub     = msh - {1'b0, n};
      ssh      = {srem_ff, d_ff[SW-1:SW-2]};
      strial   = {{(RW-HW){1'b0}}, root_ff, 2'b01};
      mean_ext = {{(BW-SB){1'b0}}, mq_ff[SB-1:0]};
      dev      = acc_ff[bbs_pkg::GAIN_FRAC +: BW];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wlen_in      = wlen_ff;
      gain_in      = gain_ff;
      s_in         = s_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      mc_in        = mc_ff << 1;
      mp_in        = mp_ff >> 1;
      acc_in       = acc_new;
      d_in         = d_ff;
      nsq_in       = nsq_ff;
      rem_in       = rem_ff;
      mq_in        = mq_ff;
      mrem_in      = mrem_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            bbs_pkg::CSR_WINDOW_LENGTH: begin
               wlen_in = csr_data[bbs_pkg::LEN_W-1:0];
               sum_in  = '0;
               sq_in   = '0;
            end
            bbs_pkg::CSR_DEVIATION_GAIN: begin
               gain_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && !suppress) begin
               s_in = req_tdata[SB-1:0];
               if (req_tuser) begin
                  sum_in = '0;
                  sq_in  = '0;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            sum_in   = sum_ff + SUMW'(s_ff) - SUMW'(old_s);
            mc_in    = MW'(s_ff);
            mp_in    = MPW'(s_ff);
            acc_in   = '0;
            cnt_in   = CNTW'(SB);
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               sq_in    = sq_ff + acc_new[SQW-1:0];
               mc_in    = MW'(old_s);
               mp_in    = MPW'(old_s);
               acc_in   = '0;
               cnt_in   = CNTW'(SB);
               state_in = ST_SQ2;
            end
         end
         ST_SQ2: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               sq_in    = sq_ff - acc_new[SQW-1:0];
               mc_in    = MW'(sq_in);
               mp_in    = MPW'(n);
               acc_in   = '0;
               cnt_in   = CNTW'(NW);
               state_in = ST_MA;
            end
         end
         ST_MA: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               d_in     = acc_new[SW-1:0];
               mc_in    = MW'(sum_ff);
               mp_in    = MPW'(sum_ff);
               acc_in   = '0;
               cnt_in   = CNTW'(SUMW);
               state_in = ST_MB;
            end
         end
         ST_MB: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               d_in     = d_ff - acc_new[SW-1:0];
               mc_in    = MW'(n);
               mp_in    = MPW'(n);
               acc_in   = '0;
               cnt_in   = CNTW'(NW);
               state_in = ST_MN;
            end
         end
         ST_MN: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               nsq_in   = acc_new[2*NW-1:0];
               rem_in   = '0;
               cnt_in   = CNTW'(SW);
               state_in = ST_DV;
            end
         end
         // variance: restoring divide by n squared
         ST_DV: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (!dsub[2*NW]) begin
               rem_in = dsub[2*NW-1:0];
               d_in   = {d_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = dsh[2*NW-1:0];
               d_in   = {d_ff[SW-2:0], 1'b0};
            end
            if (mul_last) begin
               mq_in    = sum_ff;
               mrem_in  = '0;
               cnt_in   = CNTW'(SUMW);
               state_in = ST_DM;
            end
         end
         // mean: restoring divide by n
         ST_DM: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (!msub[NW]) begin
               mrem_in = msub[NW-1:0];
               mq_in   = {mq_ff[SUMW-2:0], 1'b1};
            end else begin
               mrem_in = msh[NW-1:0];
               mq_in   = {mq_ff[SUMW-2:0], 1'b0};
            end
            if (mul_last) begin
               root_in  = '0;
               srem_in  = '0;
               cnt_in   = CNTW'(HW);
               state_in = ST_SR;
            end
         end
         // square root, one bit pair per cycle
         ST_SR: begin
            cnt_in = cnt_ff - CNTW'(1);
            d_in   = d_ff << 2;
            if (ssh >= strial) begin
               srem_in = RW'(ssh - strial);
               root_in = {root_ff[HW-2:0], 1'b1};
            end else begin
               srem_in = RW'(ssh);
               root_in = {root_ff[HW-2:0], 1'b0};
            end
            if (mul_last) begin
               mc_in    = MW'(root_in);
               mp_in    = MPW'(gain_ff);
               acc_in   = '0;
               cnt_in   = CNTW'(bbs_pkg::GAIN_W);
               state_in = ST_MG;
            end
         end
         ST_MG: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (mul_last) begin
               state_in = ST_OUT;
            end
         end
         // hand over to the output register
         ST_OUT: begin
            acc_in = acc_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {mean_ext - dev, mean_ext + dev,
                               bbs_pkg::MEAN_W'(mq_ff[SB-1:0])};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= bbs_pkg::LEN_RESET;
         gain_ff      <= bbs_pkg::GAIN_RESET;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         gain_ff      <= gain_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      mc_ff       <= mc_in;
      mp_ff       <= mp_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      nsq_ff      <= nsq_in;
      rem_ff      <= rem_in;
      mq_ff       <= mq_in;
      mrem_ff     <= mrem_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a request in flight is checked to have a nonempty window
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (n != '0))
      else $error("window empty while a request is in flight");

   // variance remainder stays below n squared
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DM) |-> (rem_ff < nsq_ff))
      else $error("divider remainder not below divisor");

   // square root remainder bounded by twice the root
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MG) |-> (srem_ff <= {root_ff, 1'b0}))
      else $error("square root remainder out of range");
`endif

endmodule
